[rtl/mfdot_pkg.sv]
package mfdot_pkg;

    typedef enum logic [1:0] {
        CMD_LOAD_NODE = 2'd0,
        CMD_ADD_FACE  = 2'd1,
        CMD_FIND_FACE = 2'd2,
        CMD_NONE      = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        STS_OK         = 3'd0,
        STS_PAIRED     = 3'd1,
        STS_LIST_FULL  = 3'd2,
        STS_TABLE_FULL = 3'd3,
        STS_NOT_FOUND  = 3'd4
    } status_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_CNT0,
        S_CNT1,
        S_CNT2,
        S_ROOM,
        S_SRCH,
        S_SIS,
        S_CRDA,
        S_CRDB,
        S_CRDC,
        S_CRDO,
        S_MLOAD,
        S_MRUN,
        S_ORIENT,
        S_WR0,
        S_WR1,
        S_WR2,
        S_FSIS,
        S_DONE
    } state_t;

    // multiply schedule: six cross-product terms, then three dot-product terms
    localparam int DIGIT_W   = 8;
    localparam int STEP_LAST = 8;

endpackage

[rtl/mfdot_ram.sv]
module mfdot_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/mesh_face_dedup_orient_table.sv]
// Each command is decoded first; load_node, bad index, unknown command and table full then go
//   to the result; find_face reads the count at vert_a and searches that list; add_face reads
//   all three counts, answers list full or searches, reads coordinates, runs the MAC, writes.
// Throughput: one transaction at a time, set by the face-list search and the 8-bit-digit MAC;
//   a result held by m_ready low stalls the next transaction.
// Reset: synchronous active-low; then the face count of every node is cleared, s_ready low.
module mesh_face_dedup_orient_table #(
    parameter int NODE_COUNT     = 4096,
    parameter int FACE_DEPTH     = 16384,
    parameter int FACES_PER_NODE = 32,
    parameter int COORD_WIDTH    = 32
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_cmd,
    input  logic [11:0]        s_node_index,
    input  logic signed [31:0] s_coord_x,
    input  logic signed [31:0] s_coord_y,
    input  logic signed [31:0] s_coord_z,
    input  logic [11:0]        s_vert_a,
    input  logic [11:0]        s_vert_b,
    input  logic [11:0]        s_vert_c,
    input  logic [11:0]        s_opposite_node,
    input  logic [7:0]         s_label_color,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [13:0]        m_face_index,
    output logic               m_sister_found,
    output logic [13:0]        m_sister_index,
    output logic               m_order_swapped,
    output logic [2:0]         m_status
);

    localparam int NW  = $clog2(NODE_COUNT);
    localparam int FW  = $clog2(FACE_DEPTH);
    localparam int SW  = $clog2(FACES_PER_NODE);
    localparam int KW  = $clog2(FACES_PER_NODE + 1);
    localparam int CW  = COORD_WIDTH;
    localparam int CRW = 3 * CW;
    localparam int DW  = CW + 1;
    localparam int DG  = mfdot_pkg::DIGIT_W;
    localparam int ND  = (DW + DG - 1) / DG;
    localparam int BW  = ND * DG;
    localparam int MW  = $clog2(ND);
    localparam int RW  = 3 * CW + 8;
    localparam int LD  = NODE_COUNT << SW;

    // ---------------- registers ----------------
    mfdot_pkg::state_t  state_reg, state_next;
    logic [NW-1:0]      clr_reg, clr_next;
    logic [FW:0]        next_face_reg, next_face_next;
    logic               m_valid_reg, m_valid_next;

    mfdot_pkg::cmd_t    cmd_reg, cmd_next;
    logic [11:0]        nidx_reg, nidx_next;
    logic [CW-1:0]      cx_reg, cx_next, cy_reg, cy_next, cz_reg, cz_next;
    logic [11:0]        va_reg, va_next, vb_reg, vb_next, vc_reg, vc_next, vo_reg, vo_next;
    logic [7:0]         label_reg, label_next;

    logic [KW-1:0]      cnt_reg [3];
    logic [KW-1:0]      cnt_next [3];
    logic [KW-1:0]      srch_idx_reg, srch_idx_next;
    logic               p1_reg, p1_next, p2_reg, p2_next;
    logic [FW-1:0]      p2_face_reg, p2_face_next;
    logic               hit_reg, hit_next;
    logic [FW-1:0]      hit_face_reg, hit_face_next;
    logic               sis_valid_reg, sis_valid_next;

    logic [CRW-1:0]     crd_a_reg, crd_a_next;
    logic signed [DW-1:0] eb_reg [3];
    logic signed [DW-1:0] eb_next [3];
    logic signed [DW-1:0] ec_reg [3];
    logic signed [DW-1:0] ec_next [3];
    logic signed [DW-1:0] eo_reg [3];
    logic signed [DW-1:0] eo_next [3];

    logic [3:0]         step_reg, step_next;
    logic [MW-1:0]      mcnt_reg, mcnt_next;
    logic signed [RW-1:0] a_reg, a_next;
    logic signed [BW-1:0] b_reg, b_next;
    logic signed [RW-1:0] acc_reg, acc_next;
    logic signed [RW-1:0] nx_reg, nx_next, ny_reg, ny_next, nz_reg, nz_next;

    logic [NW-1:0]      w_reg [3];
    logic [NW-1:0]      w_next [3];
    logic [SW-1:0]      pos_reg [3];
    logic [SW-1:0]      pos_next [3];
    logic [KW-1:0]      ncnt_reg [3];
    logic [KW-1:0]      ncnt_next [3];

    logic [FW-1:0]      res_face_reg, res_face_next;
    logic               res_sfound_reg, res_sfound_next;
    logic [FW-1:0]      res_sidx_reg, res_sidx_next;
    logic               res_swap_reg, res_swap_next;
    mfdot_pkg::status_t res_status_reg, res_status_next;

    logic [13:0]        m_face_reg, m_face_next, m_sidx_reg, m_sidx_next;
    logic               m_sfound_reg, m_sfound_next, m_swap_reg, m_swap_next;
    logic [2:0]         m_status_reg, m_status_next;

    // ---------------- memory ports ----------------
    logic               crd_we;
    logic [NW-1:0]      crd_waddr, crd_raddr;
    logic [CRW-1:0]     crd_wdata, crd_rdata;
    logic               cnt_we;
    logic [NW-1:0]      cnt_waddr, cnt_raddr;
    logic [KW-1:0]      cnt_wdata, cnt_rdata;
    logic               lst_we;
    logic [NW+SW-1:0]   lst_waddr, lst_raddr;
    logic [FW-1:0]      lst_wdata, lst_rdata;
    logic               fv_we;
    logic [FW-1:0]      fv_waddr, fv_raddr;
    logic [3*NW-1:0]    fv_wdata, fv_rdata;
    logic               sis_we;
    logic [FW-1:0]      sis_waddr, sis_raddr;
    logic [FW:0]        sis_wdata, sis_rdata;
    logic               mat_we;
    logic [FW-1:0]      mat_waddr;
    logic [7:0]         mat_wdata;
    logic               pat_we;
    logic [FW-1:0]      pat_waddr;
    logic [8:0]         pat_wdata;

    mfdot_ram #(.WIDTH(CRW), .DEPTH(NODE_COUNT)) u_coords (
        .aclk(aclk), .wr_en(crd_we), .wr_addr(crd_waddr), .wr_data(crd_wdata),
        .rd_addr(crd_raddr), .rd_data(crd_rdata)
    );
    mfdot_ram #(.WIDTH(KW), .DEPTH(NODE_COUNT)) u_counts (
        .aclk(aclk), .wr_en(cnt_we), .wr_addr(cnt_waddr), .wr_data(cnt_wdata),
        .rd_addr(cnt_raddr), .rd_data(cnt_rdata)
    );
    mfdot_ram #(.WIDTH(FW), .DEPTH(LD)) u_lists (
        .aclk(aclk), .wr_en(lst_we), .wr_addr(lst_waddr), .wr_data(lst_wdata),
        .rd_addr(lst_raddr), .rd_data(lst_rdata)
    );
    mfdot_ram #(.WIDTH(3 * NW), .DEPTH(FACE_DEPTH)) u_fverts (
        .aclk(aclk), .wr_en(fv_we), .wr_addr(fv_waddr), .wr_data(fv_wdata),
        .rd_addr(fv_raddr), .rd_data(fv_rdata)
    );
    mfdot_ram #(.WIDTH(FW + 1), .DEPTH(FACE_DEPTH)) u_sister (
        .aclk(aclk), .wr_en(sis_we), .wr_addr(sis_waddr), .wr_data(sis_wdata),
        .rd_addr(sis_raddr), .rd_data(sis_rdata)
    );
    // material and patch color are kept per face; nothing on the ports reads them back
    mfdot_ram #(.WIDTH(8), .DEPTH(FACE_DEPTH)) u_material (
        .aclk(aclk), .wr_en(mat_we), .wr_addr(mat_waddr), .wr_data(mat_wdata),
        .rd_addr(mat_waddr), .rd_data()
    );
    mfdot_ram #(.WIDTH(9), .DEPTH(FACE_DEPTH)) u_patch (
        .aclk(aclk), .wr_en(pat_we), .wr_addr(pat_waddr), .wr_data(pat_wdata),
        .rd_addr(pat_waddr), .rd_data()
    );

    // ---------------- helpers ----------------
    function automatic logic signed [DW-1:0] coord_diff(input logic [CW-1:0] p,
                                                        input logic [CW-1:0] q);
        return $signed({p[CW-1], p}) - $signed({q[CW-1], q});
    endfunction

    logic [NW-1:0] na, nb, nc, no;
    logic          a_ok, b_ok, c_ok, o_ok;
    assign na = NW'(va_reg);
    assign nb = NW'(vb_reg);
    assign nc = NW'(vc_reg);
    assign no = NW'(vo_reg);
    assign a_ok = int'(va_reg) < NODE_COUNT;
    assign b_ok = int'(vb_reg) < NODE_COUNT;
    assign c_ok = int'(vc_reg) < NODE_COUNT;
    assign o_ok = int'(vo_reg) < NODE_COUNT;

    // one 8-bit digit of the narrow operand per cycle; the top digit is signed
    logic                 last_digit;
    logic signed [8:0]    digit;
    logic signed [RW+8:0] prod;
    logic signed [RW-1:0] acc_sum;
    assign last_digit = (mcnt_reg == MW'(ND - 1));
    assign digit   = last_digit ? {b_reg[7], b_reg[7:0]} : {1'b0, b_reg[7:0]};
    assign prod    = a_reg * digit;
    assign acc_sum = acc_reg + prod[RW-1:0];

    logic signed [RW-1:0] op_a;
    logic signed [DW-1:0] op_b;
    always_comb begin
        unique case (step_reg)
            4'd0: begin op_a = RW'(eb_reg[1]);    op_b = ec_reg[2]; end
            4'd1: begin op_a = -(RW'(ec_reg[1])); op_b = eb_reg[2]; end
            4'd2: begin op_a = RW'(eb_reg[2]);    op_b = ec_reg[0]; end
            4'd3: begin op_a = -(RW'(ec_reg[2])); op_b = eb_reg[0]; end
            4'd4: begin op_a = RW'(eb_reg[0]);    op_b = ec_reg[1]; end
            4'd5: begin op_a = -(RW'(ec_reg[0])); op_b = eb_reg[1]; end
            4'd6: begin op_a = nx_reg;            op_b = eo_reg[0]; end
            4'd7: begin op_a = ny_reg;            op_b = eo_reg[1]; end
            default: begin op_a = nz_reg;         op_b = eo_reg[2]; end
        endcase
    end

    // list room: each vertex needs one slot per use in the triangle
    logic [1:0]    need [3];
    logic          room;
    logic [NW-1:0] tv [3];
    always_comb begin
        tv[0] = na;
        tv[1] = nb;
        tv[2] = nc;
        room = 1'b1;
        for (int j = 0; j < 3; j++) begin
            need[j] = 2'(tv[0] == tv[j]) + 2'(tv[1] == tv[j]) + 2'(tv[2] == tv[j]);
            if ((KW + 2)'(cnt_reg[j]) + (KW + 2)'(need[j]) > (KW + 2)'(FACES_PER_NODE)) begin
                room = 1'b0;
            end
        end
    end

    logic          swap;
    logic [NW-1:0] wo [3];
    logic [KW-1:0] wc [3];
    assign swap  = !acc_reg[RW-1] && (acc_reg != '0);
    assign wo[0] = swap ? nb : na;
    assign wo[1] = swap ? na : nb;
    assign wo[2] = nc;
    assign wc[0] = swap ? cnt_reg[1] : cnt_reg[0];
    assign wc[1] = swap ? cnt_reg[0] : cnt_reg[1];
    assign wc[2] = cnt_reg[2];

    logic srch_issue, srch_match, srch_done;
    logic [NW-1:0] fv_n [3];
    always_comb begin
        srch_match = p2_reg;
        for (int j = 0; j < 3; j++) begin
            fv_n[j] = fv_rdata[j*NW +: NW];
            if (fv_n[j] != na && fv_n[j] != nb && fv_n[j] != nc) begin
                srch_match = 1'b0;
            end
        end
    end
    assign srch_issue = srch_idx_reg < cnt_reg[0];
    assign srch_done  = srch_match || (!srch_issue && !p1_reg && !p2_reg);

    logic [FW-1:0] cur_face;
    assign cur_face = next_face_reg[FW-1:0];

    // ---------------- control ----------------
    always_comb begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        next_face_next  = next_face_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        cmd_next        = cmd_reg;
        nidx_next       = nidx_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        cz_next         = cz_reg;
        va_next         = va_reg;
        vb_next         = vb_reg;
        vc_next         = vc_reg;
        vo_next         = vo_reg;
        label_next      = label_reg;
        cnt_next        = cnt_reg;
        srch_idx_next   = srch_idx_reg;
        p1_next         = p1_reg;
        p2_next         = p2_reg;
        p2_face_next    = p2_face_reg;
        hit_next        = hit_reg;
        hit_face_next   = hit_face_reg;
        sis_valid_next  = sis_valid_reg;
        crd_a_next      = crd_a_reg;
        eb_next         = eb_reg;
        ec_next         = ec_reg;
        eo_next         = eo_reg;
        step_next       = step_reg;
        mcnt_next       = mcnt_reg;
        a_next          = a_reg;
        b_next          = b_reg;
        acc_next        = acc_reg;
        nx_next         = nx_reg;
        ny_next         = ny_reg;
        nz_next         = nz_reg;
        w_next          = w_reg;
        pos_next        = pos_reg;
        ncnt_next       = ncnt_reg;
        res_face_next   = res_face_reg;
        res_sfound_next = res_sfound_reg;
        res_sidx_next   = res_sidx_reg;
        res_swap_next   = res_swap_reg;
        res_status_next = res_status_reg;
        m_face_next     = m_face_reg;
        m_sfound_next   = m_sfound_reg;
        m_sidx_next     = m_sidx_reg;
        m_swap_next     = m_swap_reg;
        m_status_next   = m_status_reg;

        crd_we    = 1'b0;
        crd_waddr = NW'(nidx_reg);
        crd_wdata = {cz_reg, cy_reg, cx_reg};
        crd_raddr = na;
        cnt_we    = 1'b0;
        cnt_waddr = NW'(nidx_reg);
        cnt_wdata = '0;
        cnt_raddr = na;
        lst_we    = 1'b0;
        lst_waddr = {w_reg[0], pos_reg[0]};
        lst_wdata = cur_face;
        lst_raddr = {na, srch_idx_reg[SW-1:0]};
        fv_we     = 1'b0;
        fv_waddr  = cur_face;
        fv_wdata  = {w_reg[2], w_reg[1], w_reg[0]};
        fv_raddr  = lst_rdata;
        sis_we    = 1'b0;
        sis_waddr = cur_face;
        sis_wdata = hit_reg ? {1'b1, hit_face_reg} : '0;
        sis_raddr = p2_face_reg;
        mat_we    = 1'b0;
        mat_waddr = cur_face;
        mat_wdata = label_reg;
        pat_we    = 1'b0;
        pat_waddr = cur_face;
        pat_wdata = '0;

        s_ready = (state_reg == mfdot_pkg::S_IDLE);

        unique case (state_reg)
            mfdot_pkg::S_CLEAR: begin
                cnt_we    = 1'b1;
                cnt_waddr = clr_reg;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == NW'(NODE_COUNT - 1)) begin
                    state_next = mfdot_pkg::S_IDLE;
                end
            end
            mfdot_pkg::S_IDLE: begin
                if (s_valid) begin
                    cmd_next        = mfdot_pkg::cmd_t'(s_cmd);
                    nidx_next       = s_node_index;
                    cx_next         = CW'(s_coord_x);
                    cy_next         = CW'(s_coord_y);
                    cz_next         = CW'(s_coord_z);
                    va_next         = s_vert_a;
                    vb_next         = s_vert_b;
                    vc_next         = s_vert_c;
                    vo_next         = s_opposite_node;
                    label_next      = s_label_color;
                    res_face_next   = '0;
                    res_sfound_next = 1'b0;
                    res_sidx_next   = '0;
                    res_swap_next   = 1'b0;
                    res_status_next = mfdot_pkg::STS_OK;
                    state_next      = mfdot_pkg::S_DECODE;
                end
            end
            mfdot_pkg::S_DECODE: begin
                unique case (cmd_reg)
                    mfdot_pkg::CMD_LOAD_NODE: begin
                        if (int'(nidx_reg) >= NODE_COUNT) begin
                            res_status_next = mfdot_pkg::STS_NOT_FOUND;
                        end else begin
                            crd_we = 1'b1;
                            cnt_we = 1'b1;
                        end
                        state_next = mfdot_pkg::S_DONE;
                    end
                    mfdot_pkg::CMD_ADD_FACE: begin
                        if (!(a_ok && b_ok && c_ok && o_ok)) begin
                            res_status_next = mfdot_pkg::STS_NOT_FOUND;
                            state_next      = mfdot_pkg::S_DONE;
                        end else if (next_face_reg >= (FW + 1)'(FACE_DEPTH)) begin
                            res_status_next = mfdot_pkg::STS_TABLE_FULL;
                            state_next      = mfdot_pkg::S_DONE;
                        end else begin
                            state_next = mfdot_pkg::S_CNT0;
                        end
                    end
                    mfdot_pkg::CMD_FIND_FACE: begin
                        if (!(a_ok && b_ok && c_ok)) begin
                            res_status_next = mfdot_pkg::STS_NOT_FOUND;
                            state_next      = mfdot_pkg::S_DONE;
                        end else begin
                            state_next = mfdot_pkg::S_CNT0;
                        end
                    end
                    mfdot_pkg::CMD_NONE: begin
                        res_status_next = mfdot_pkg::STS_NOT_FOUND;
                        state_next      = mfdot_pkg::S_DONE;
                    end
                endcase
            end
            mfdot_pkg::S_CNT0: begin
                cnt_next[0] = cnt_rdata;
                cnt_raddr   = nb;
                if (cmd_reg == mfdot_pkg::CMD_FIND_FACE) begin
                    srch_idx_next = '0;
                    p1_next       = 1'b0;
                    p2_next       = 1'b0;
                    state_next    = mfdot_pkg::S_SRCH;
                end else begin
                    state_next = mfdot_pkg::S_CNT1;
                end
            end
            mfdot_pkg::S_CNT1: begin
                cnt_next[1] = cnt_rdata;
                cnt_raddr   = nc;
                state_next  = mfdot_pkg::S_CNT2;
            end
            mfdot_pkg::S_CNT2: begin
                cnt_next[2] = cnt_rdata;
                state_next  = mfdot_pkg::S_ROOM;
            end
            mfdot_pkg::S_ROOM: begin
                if (!room) begin
                    res_status_next = mfdot_pkg::STS_LIST_FULL;
                    state_next      = mfdot_pkg::S_DONE;
                end else begin
                    srch_idx_next = '0;
                    p1_next       = 1'b0;
                    p2_next       = 1'b0;
                    state_next    = mfdot_pkg::S_SRCH;
                end
            end
            mfdot_pkg::S_SRCH: begin
                // list read, face-vertex read and compare overlap, one entry per cycle
                if (srch_issue) begin
                    srch_idx_next = srch_idx_reg + 1'b1;
                end
                p1_next      = srch_issue;
                p2_next      = p1_reg;
                p2_face_next = lst_rdata;
                if (srch_done) begin
                    hit_next      = srch_match;
                    hit_face_next = p2_face_reg;
                    if (cmd_reg == mfdot_pkg::CMD_ADD_FACE) begin
                        state_next = mfdot_pkg::S_SIS;
                    end else if (srch_match) begin
                        pat_we        = 1'b1;
                        pat_waddr     = p2_face_reg;
                        pat_wdata     = {1'b1, label_reg};
                        res_face_next = p2_face_reg;
                        state_next    = mfdot_pkg::S_FSIS;
                    end else begin
                        res_status_next = mfdot_pkg::STS_NOT_FOUND;
                        state_next      = mfdot_pkg::S_DONE;
                    end
                end
            end
            mfdot_pkg::S_SIS: begin
                sis_valid_next  = sis_rdata[FW];
                res_face_next   = cur_face;
                res_sfound_next = hit_reg;
                res_sidx_next   = hit_reg ? hit_face_reg : '0;
                if (hit_reg && sis_rdata[FW]) begin
                    res_status_next = mfdot_pkg::STS_PAIRED;
                end
                crd_raddr  = na;
                state_next = mfdot_pkg::S_CRDA;
            end
            mfdot_pkg::S_CRDA: begin
                crd_a_next = crd_rdata;
                crd_raddr  = nb;
                state_next = mfdot_pkg::S_CRDB;
            end
            mfdot_pkg::S_CRDB: begin
                for (int ax = 0; ax < 3; ax++) begin
                    eb_next[ax] = coord_diff(crd_rdata[ax*CW +: CW], crd_a_reg[ax*CW +: CW]);
                end
                crd_raddr  = nc;
                state_next = mfdot_pkg::S_CRDC;
            end
            mfdot_pkg::S_CRDC: begin
                for (int ax = 0; ax < 3; ax++) begin
                    ec_next[ax] = coord_diff(crd_rdata[ax*CW +: CW], crd_a_reg[ax*CW +: CW]);
                end
                crd_raddr  = no;
                state_next = mfdot_pkg::S_CRDO;
            end
            mfdot_pkg::S_CRDO: begin
                for (int ax = 0; ax < 3; ax++) begin
                    eo_next[ax] = coord_diff(crd_rdata[ax*CW +: CW], crd_a_reg[ax*CW +: CW]);
                end
                step_next  = '0;
                state_next = mfdot_pkg::S_MLOAD;
            end
            mfdot_pkg::S_MLOAD: begin
                a_next    = op_a;
                b_next    = BW'(op_b);
                mcnt_next = '0;
                // steps 0, 2, 4 and 6 open a new sum; at 2, 4 and 6 the finished cross term is parked first
                unique case (step_reg)
                    4'd0: acc_next = '0;
                    4'd2: begin nx_next = acc_reg; acc_next = '0; end
                    4'd4: begin ny_next = acc_reg; acc_next = '0; end
                    4'd6: begin nz_next = acc_reg; acc_next = '0; end
                    default: acc_next = acc_reg;
                endcase
                state_next = mfdot_pkg::S_MRUN;
            end
            mfdot_pkg::S_MRUN: begin
                acc_next  = acc_sum;
                a_next    = a_reg <<< DG;
                b_next    = b_reg >>> DG;
                mcnt_next = mcnt_reg + 1'b1;
                if (last_digit) begin
                    if (step_reg == 4'(mfdot_pkg::STEP_LAST)) begin
                        state_next = mfdot_pkg::S_ORIENT;
                    end else begin
                        step_next  = step_reg + 1'b1;
                        state_next = mfdot_pkg::S_MLOAD;
                    end
                end
            end
            mfdot_pkg::S_ORIENT: begin
                // acc holds the dot product; positive means the normal faces the inside
                res_swap_next = swap;
                for (int j = 0; j < 3; j++) begin
                    w_next[j] = wo[j];
                    ncnt_next[j] = wc[j] + KW'(wo[0] == wo[j]) + KW'(wo[1] == wo[j])
                                 + KW'(wo[2] == wo[j]);
                end
                pos_next[0] = SW'(wc[0]);
                pos_next[1] = SW'(wc[1] + KW'(wo[0] == wo[1]));
                pos_next[2] = SW'(wc[2] + KW'(wo[0] == wo[2]) + KW'(wo[1] == wo[2]));
                state_next = mfdot_pkg::S_WR0;
            end
            mfdot_pkg::S_WR0: begin
                fv_we      = 1'b1;
                sis_we     = 1'b1;
                mat_we     = 1'b1;
                pat_we     = 1'b1;
                cnt_we     = 1'b1;
                cnt_waddr  = w_reg[0];
                cnt_wdata  = ncnt_reg[0];
                lst_we     = 1'b1;
                state_next = mfdot_pkg::S_WR1;
            end
            mfdot_pkg::S_WR1: begin
                cnt_we    = 1'b1;
                cnt_waddr = w_reg[1];
                cnt_wdata = ncnt_reg[1];
                lst_we    = 1'b1;
                lst_waddr = {w_reg[1], pos_reg[1]};
                if (hit_reg && !sis_valid_reg) begin
                    sis_we    = 1'b1;
                    sis_waddr = hit_face_reg;
                    sis_wdata = {1'b1, cur_face};
                end
                state_next = mfdot_pkg::S_WR2;
            end
            mfdot_pkg::S_WR2: begin
                cnt_we         = 1'b1;
                cnt_waddr      = w_reg[2];
                cnt_wdata      = ncnt_reg[2];
                lst_we         = 1'b1;
                lst_waddr      = {w_reg[2], pos_reg[2]};
                next_face_next = next_face_reg + 1'b1;
                state_next     = mfdot_pkg::S_DONE;
            end
            mfdot_pkg::S_FSIS: begin
                if (sis_rdata[FW]) begin
                    res_sfound_next = 1'b1;
                    res_sidx_next   = sis_rdata[FW-1:0];
                end
                state_next = mfdot_pkg::S_DONE;
            end
            mfdot_pkg::S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_face_next   = 14'(res_face_reg);
                    m_sfound_next = res_sfound_reg;
                    m_sidx_next   = 14'(res_sidx_reg);
                    m_swap_next   = res_swap_reg;
                    m_status_next = res_status_reg;
                    state_next    = mfdot_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = mfdot_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= mfdot_pkg::S_CLEAR;
            clr_reg       <= '0;
            next_face_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            next_face_reg <= next_face_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        nidx_reg       <= nidx_next;
        cx_reg         <= cx_next;
        cy_reg         <= cy_next;
        cz_reg         <= cz_next;
        va_reg         <= va_next;
        vb_reg         <= vb_next;
        vc_reg         <= vc_next;
        vo_reg         <= vo_next;
        label_reg      <= label_next;
        cnt_reg        <= cnt_next;
        srch_idx_reg   <= srch_idx_next;
        p1_reg         <= p1_next;
        p2_reg         <= p2_next;
        p2_face_reg    <= p2_face_next;
        hit_reg        <= hit_next;
        hit_face_reg   <= hit_face_next;
        sis_valid_reg  <= sis_valid_next;
        crd_a_reg      <= crd_a_next;
        eb_reg         <= eb_next;
        ec_reg         <= ec_next;
        eo_reg         <= eo_next;
        step_reg       <= step_next;
        mcnt_reg       <= mcnt_next;
        a_reg          <= a_next;
        b_reg          <= b_next;
        acc_reg        <= acc_next;
        nx_reg         <= nx_next;
        ny_reg         <= ny_next;
        nz_reg         <= nz_next;
        w_reg          <= w_next;
        pos_reg        <= pos_next;
        ncnt_reg       <= ncnt_next;
        res_face_reg   <= res_face_next;
        res_sfound_reg <= res_sfound_next;
        res_sidx_reg   <= res_sidx_next;
        res_swap_reg   <= res_swap_next;
        res_status_reg <= res_status_next;
        m_face_reg     <= m_face_next;
        m_sfound_reg   <= m_sfound_next;
        m_sidx_reg     <= m_sidx_next;
        m_swap_reg     <= m_swap_next;
        m_status_reg   <= m_status_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_face_index    = m_face_reg;
    assign m_sister_found  = m_sfound_reg;
    assign m_sister_index  = m_sidx_reg;
    assign m_order_swapped = m_swap_reg;
    assign m_status        = m_status_reg;

endmodule

[dv/mesh_face_dedup_orient_table_tb.sv]
module mesh_face_dedup_orient_table_tb;
    import mfdot_pkg::*;

    localparam int NODES     = 4096;
    localparam int FACES     = 16384;
    localparam int PER_NODE  = 32;
    localparam int POOL_N    = 12;
    localparam int STALL_MAX = 20000;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        cmd_t               cmd;
        logic [11:0]        node_index;
        logic signed [31:0] crd [3];
        logic [11:0]        vert [3];
        logic [11:0]        opp;
        logic [7:0]         label;
    } face_req_t;

    typedef struct {
        logic [13:0] face_index;
        logic        sister_found;
        logic [13:0] sister_index;
        logic        order_swapped;
        status_t     status;
    } face_rsp_t;

    class mesh_table_sb;
        logic signed [31:0] coords [NODES][3];
        int                 list_len [NODES];
        int                 face_list [NODES][PER_NODE];
        int                 face_vert [FACES][3];
        bit                 sis_valid [FACES];
        int                 sis_idx [FACES];
        logic [8:0]         patch [FACES];
        logic [7:0]         material [FACES];
        int                 face_next;
        face_rsp_t          pending_rsp [$];
        int                 errors;

        function new();
            foreach (list_len[i]) list_len[i] = 0;
            face_next = 0;
            errors = 0;
        endfunction

        function bit lookup(int a, int b, int c, output int hit);
            int n;
            int f;
            bit all;
            n = (list_len[a] > PER_NODE) ? PER_NODE : list_len[a];
            for (int i = 0; i < n; i++) begin
                f = face_list[a][i];
                all = 1;
                for (int j = 0; j < 3; j++)
                    if (face_vert[f][j] != a && face_vert[f][j] != b && face_vert[f][j] != c)
                        all = 0;
                if (all) begin
                    hit = f;
                    return 1;
                end
            end
            return 0;
        endfunction

        function wide_t delta(int p, int q, int ax);
            wide_t x;
            wide_t y;
            x = coords[p][ax];
            y = coords[q][ax];
            return x - y;
        endfunction

        function void note(face_req_t r);
            face_rsp_t e;
            int v [3];
            int hit;
            int need;
            int t;
            bit room;
            wide_t u0, v0, w0, u1, v1, w1, nx, ny, nz, proj;
            e = '{0, 0, 0, 0, STS_OK};
            for (int j = 0; j < 3; j++) v[j] = int'(r.vert[j]);
            case (r.cmd)
                CMD_LOAD_NODE: begin
                    for (int j = 0; j < 3; j++) coords[r.node_index][j] = r.crd[j];
                    list_len[r.node_index] = 0;
                end
                CMD_ADD_FACE: begin
                    room = 1;
                    for (int j = 0; j < 3; j++) begin
                        need = (v[0] == v[j]) + (v[1] == v[j]) + (v[2] == v[j]);
                        if (list_len[v[j]] + need > PER_NODE) room = 0;
                    end
                    if (face_next >= FACES) e.status = STS_TABLE_FULL;
                    else if (!room) e.status = STS_LIST_FULL;
                    else begin
                        e.face_index = 14'(face_next);
                        sis_valid[face_next] = 0;
                        if (lookup(v[0], v[1], v[2], hit)) begin
                            e.sister_found = 1;
                            e.sister_index = 14'(hit);
                            sis_valid[face_next] = 1;
                            sis_idx[face_next] = hit;
                            if (sis_valid[hit]) e.status = STS_PAIRED;
                            else begin
                                sis_valid[hit] = 1;
                                sis_idx[hit] = face_next;
                            end
                        end
                        u0 = delta(v[1], v[0], 0); v0 = delta(v[1], v[0], 1);
                        w0 = delta(v[1], v[0], 2);
                        u1 = delta(v[2], v[0], 0); v1 = delta(v[2], v[0], 1);
                        w1 = delta(v[2], v[0], 2);
                        nx = v0 * w1 - v1 * w0;
                        ny = w0 * u1 - w1 * u0;
                        nz = u0 * v1 - u1 * v0;
                        proj = delta(r.opp, v[0], 0) * nx + delta(r.opp, v[0], 1) * ny
                             + delta(r.opp, v[0], 2) * nz;
                        if (proj > 0) begin
                            t = v[0]; v[0] = v[1]; v[1] = t;
                            e.order_swapped = 1;
                        end
                        for (int j = 0; j < 3; j++) begin
                            face_vert[face_next][j] = v[j];
                            face_list[v[j]][list_len[v[j]] % PER_NODE] = face_next;
                            list_len[v[j]]++;
                        end
                        material[face_next] = r.label;
                        patch[face_next] = 0;
                        face_next++;
                    end
                end
                CMD_FIND_FACE: begin
                    if (lookup(v[0], v[1], v[2], hit)) begin
                        e.face_index = 14'(hit);
                        patch[hit] = {1'b1, r.label};
                        if (sis_valid[hit]) begin
                            e.sister_found = 1;
                            e.sister_index = 14'(sis_idx[hit]);
                        end
                    end else e.status = STS_NOT_FOUND;
                end
                default: e.status = STS_NOT_FOUND;
            endcase
            pending_rsp.push_back(e);
        endfunction

        function void check(face_rsp_t got);
            face_rsp_t e;
            if (pending_rsp.size() == 0) begin
                $error("unexpected result transaction, face_index %0d", got.face_index);
                errors++;
                return;
            end
            e = pending_rsp.pop_front();
            if (got.face_index !== e.face_index) begin
                $error("face_index exp %0d got %0d", e.face_index, got.face_index); errors++;
            end
            if (got.sister_found !== e.sister_found) begin
                $error("sister_found exp %0d got %0d", e.sister_found, got.sister_found);
                errors++;
            end
            if (got.sister_index !== e.sister_index) begin
                $error("sister_index exp %0d got %0d", e.sister_index, got.sister_index);
                errors++;
            end
            if (got.order_swapped !== e.order_swapped) begin
                $error("order_swapped exp %0d got %0d", e.order_swapped, got.order_swapped);
                errors++;
            end
            if (got.status !== e.status) begin
                $error("status exp %0d got %0d", e.status, got.status); errors++;
            end
        endfunction
    endclass

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_cmd;
    logic [11:0]        s_node_index;
    logic signed [31:0] s_coord_x, s_coord_y, s_coord_z;
    logic [11:0]        s_vert_a, s_vert_b, s_vert_c, s_opposite_node;
    logic [7:0]         s_label_color;
    logic               m_valid;
    logic               m_ready;
    logic [13:0]        m_face_index;
    logic               m_sister_found;
    logic [13:0]        m_sister_index;
    logic               m_order_swapped;
    logic [2:0]         m_status;

    mesh_face_dedup_orient_table dut (.*);

    mesh_table_sb sb = new();
    int           send_idle_pct;
    int           recv_idle_pct;
    int           quiet_cycles;
    logic [11:0]  pool [POOL_N];

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // result side: ready toggles at negedge, transactions checked at posedge
    initial begin
        m_ready = 0;
        forever begin
            @(negedge aclk);
            m_ready = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check('{m_face_index, m_sister_found, m_sister_index, m_order_swapped,
                       status_t'(m_status)});
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_MAX) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic push_req(face_req_t r);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 0;
            @(negedge aclk);
        end
        s_valid = 1;
        s_cmd = r.cmd;
        s_node_index = r.node_index;
        s_coord_x = r.crd[0];
        s_coord_y = r.crd[1];
        s_coord_z = r.crd[2];
        s_vert_a = r.vert[0];
        s_vert_b = r.vert[1];
        s_vert_c = r.vert[2];
        s_opposite_node = r.opp;
        s_label_color = r.label;
        do @(posedge aclk); while (!s_ready);
        sb.note(r);
    endtask

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $signed($urandom_range(2000)) - 1000;
            2: return $urandom_range(1) ? 32'sh7fffffff - $urandom_range(3)
                                         : 32'sh80000000 + $urandom_range(3);
            default: return $signed($urandom_range(200000)) - 100000;
        endcase
    endfunction

    function automatic face_req_t mk_load(logic [11:0] n, int x, int y, int z);
        face_req_t r;
        r.cmd = CMD_LOAD_NODE;
        r.node_index = n;
        r.crd = '{x, y, z};
        r.vert = '{12'($urandom), 12'($urandom), 12'($urandom)};
        r.opp = 12'($urandom);
        r.label = 8'($urandom);
        return r;
    endfunction

    function automatic face_req_t mk_tri(cmd_t c, int a, int b, int d, int o);
        face_req_t r;
        r.cmd = c;
        r.node_index = 12'($urandom);
        r.crd = '{$urandom, $urandom, $urandom};
        r.vert = '{pool[a], pool[b], pool[d]};
        r.opp = pool[o];
        r.label = 8'($urandom);
        return r;
    endfunction

    function automatic face_req_t rand_req();
        face_req_t r;
        int k;
        k = $urandom_range(99);
        if (k < 12)
            r = mk_load(pool[$urandom_range(POOL_N - 1)], rand_coord(), rand_coord(),
                        rand_coord());
        else if (k < 15)
            r = mk_load(12'($urandom), rand_coord(), rand_coord(), rand_coord());
        else if (k < 65)
            r = mk_tri(CMD_ADD_FACE, $urandom_range(5), $urandom_range(5),
                       $urandom_range(POOL_N - 1), $urandom_range(POOL_N - 1));
        else if (k < 95)
            r = mk_tri(CMD_FIND_FACE, $urandom_range(5), $urandom_range(POOL_N - 1),
                       $urandom_range(POOL_N - 1), 0);
        else begin
            r = mk_load(12'($urandom), $urandom, $urandom, $urandom);
            r.cmd = CMD_NONE;
        end
        return r;
    endfunction

    initial begin
        face_req_t r;
        aresetn = 0;
        s_valid = 0;
        s_cmd = CMD_LOAD_NODE;
        s_node_index = 0;
        s_coord_x = 0;
        s_coord_y = 0;
        s_coord_z = 0;
        s_vert_a = 0;
        s_vert_b = 0;
        s_vert_c = 0;
        s_opposite_node = 0;
        s_label_color = 0;
        send_idle_pct = 30;
        recv_idle_pct = 48;
        pool[0] = 0;
        pool[1] = 12'hfff;
        for (int i = 2; i < POOL_N; i++) pool[i] = 12'($urandom);
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // directed: simple frame, collinear point, coordinate extremes
        push_req(mk_load(pool[0], 0, 0, 0));
        push_req(mk_load(pool[1], 1000, 0, 0));
        push_req(mk_load(pool[2], 0, 1000, 0));
        push_req(mk_load(pool[3], 0, 0, 1000));
        push_req(mk_load(pool[4], 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff));
        push_req(mk_load(pool[5], 32'sh80000000, 32'sh80000000, 32'sh80000000));
        push_req(mk_load(pool[6], 2000, 0, 0));
        for (int i = 7; i < POOL_N; i++)
            push_req(mk_load(pool[i], rand_coord(), rand_coord(), rand_coord()));
        push_req(mk_tri(CMD_ADD_FACE, 0, 1, 2, 3));   // normal toward opposite: swap
        push_req(mk_tri(CMD_ADD_FACE, 1, 0, 2, 3));   // sister of the first
        push_req(mk_tri(CMD_ADD_FACE, 2, 0, 1, 3));   // third sharer
        push_req(mk_tri(CMD_ADD_FACE, 0, 1, 6, 3));   // degenerate normal
        push_req(mk_tri(CMD_ADD_FACE, 4, 5, 0, 1));
        push_req(mk_tri(CMD_ADD_FACE, 5, 4, 1, 2));
        push_req(mk_tri(CMD_ADD_FACE, 4, 4, 4, 5));
        push_req(mk_tri(CMD_FIND_FACE, 0, 2, 1, 0));
        push_req(mk_tri(CMD_FIND_FACE, 3, 4, 5, 0));  // miss
        push_req(mk_tri(CMD_FIND_FACE, 4, 5, 0, 0));
        r = mk_load(12'($urandom), $urandom, $urandom, $urandom);
        r.cmd = CMD_NONE;
        push_req(r);

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 30 : (ph == 1) ? 48 : 0;
            recv_idle_pct = (ph == 0) ? 48 : (ph == 1) ? 30 : 0;
            for (int i = 0; i < 560; i++) push_req(rand_req());
        end
        @(negedge aclk);
        s_valid = 0;

        while (sb.pending_rsp.size() > 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
        if (sb.errors == 0 && sb.pending_rsp.size() == 0) $display("== PASS ==");
        else $display("== FAIL ==");
        $finish;
    end
endmodule

[sim.f]
rtl/mfdot_pkg.sv
rtl/mfdot_ram.sv
rtl/mesh_face_dedup_orient_table.sv
dv/mesh_face_dedup_orient_table_tb.sv
